/* design/yprgb_pkg.sv */
package yprgb_pkg;

   // Frame size limits; memory depths and address widths follow from these.
   localparam int MAX_WIDTH  = 640;
   localparam int MAX_HEIGHT = 480;

   localparam int HALF_W = MAX_WIDTH / 2;
   localparam int HALF_H = MAX_HEIGHT / 2;

   // Luma is kept as horizontal pairs, one 16-bit word per two pixels.
   localparam int LUMA_DEPTH = HALF_W * MAX_HEIGHT;
   localparam int LUMA_AW    = $clog2(LUMA_DEPTH);
   localparam int CB_DEPTH   = HALF_W * HALF_H;
   localparam int CB_AW      = $clog2(CB_DEPTH);

   // Field and register widths
   localparam int BYTE_W = 8;
   localparam int FW_W   = 10;
   localparam int FH_W   = 9;
   localparam int CSR_W  = 10;

   // Largest even size that the size registers can hold, capped by the limits
   localparam logic [FW_W-1:0] W_CAP =
      (MAX_WIDTH > (2**FW_W) - 2) ? FW_W'((2**FW_W) - 2) : FW_W'(MAX_WIDTH);
   localparam logic [FH_W-1:0] H_CAP =
      (MAX_HEIGHT > (2**FH_W) - 2) ? FH_W'((2**FH_W) - 2) : FH_W'(MAX_HEIGHT);

   // Register indexes
   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(640);
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(480);

   // Clamp limits and offsets
   localparam logic [BYTE_W-1:0] LUMA_LO   = 8'd16;
   localparam logic [BYTE_W-1:0] LUMA_HI   = 8'd235;
   localparam logic [BYTE_W-1:0] CHROMA_LO = 8'd16;
   localparam logic [BYTE_W-1:0] CHROMA_HI = 8'd240;
   localparam logic [BYTE_W-1:0] LUMA_OFS  = 8'd16;
   localparam logic [BYTE_W:0]   CHROMA_OFS = 9'd128;

   // BT.601 coefficients scaled by 1024
   localparam logic [10:0]        COEF_Y  = 11'd1192;
   localparam logic signed [12:0] COEF_RV = 13'sd1634;
   localparam logic signed [12:0] COEF_GU = 13'sd401;
   localparam logic signed [12:0] COEF_GV = 13'sd833;
   localparam logic signed [12:0] COEF_BU = 13'sd2065;

   localparam int SUM_W  = 21;
   localparam int YSC_W  = 18;
   localparam int FRAC_W = 10;

   typedef enum logic [1:0] {
      PHASE_LUMA = 2'd0,
      PHASE_BLUE = 2'd1,
      PHASE_RED  = 2'd2
   } phase_type;

endpackage

/* design/yprgb_ram.sv */
module yprgb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // read data holds until the next read
      if (rd_en) begin
         rd_data_a_ff <= mem[rd_addr_a];
         rd_data_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

/* design/yuv420_planar_to_rgb.sv */
// Planar 4:2:0 YCbCr (BT.601 studio range) to RGB converter.
//
// req channel: one raw byte per transaction, the whole Y plane of a frame
// in raster order, then the quarter-size Cb plane, then the Cr plane.
// Y and Cb transactions are stored and return nothing; they are taken one
// per cycle and never stalled. Each Cr transaction returns four rsp
// transactions, the 2x2 block top-left, top-right, bottom-left,
// bottom-right, with row, column, clamped RGB and frame_done on the last
// pixel of the frame.
// A taken Cr byte is read into s1, moves on to the block buffer (s2) and
// its first pixel into the rsp register; the other three follow unless stalled.
// The single rsp register emits one pixel per cycle unless rsp_stall holds
// it; a Cr byte can be taken while s2 still emits the previous block, but
// is held off (req_stall) while the read stage is still occupied.
// rsp_stall holds the output register; the block buffer and read stage back
// up behind it and req_stall rises in the Cr plane only.
// csr: a write to frame_width or frame_height restarts the frame at the
// luma plane; write only while idle. Reset loads 640x480 and the luma
// plane; the pixel memories are not cleared and need no clearing pass.
module yuv420_planar_to_rgb (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_plane_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [8:0] rsp_pixel_row,
   output logic [9:0] rsp_pixel_col,
   output logic [7:0] rsp_red,
   output logic [7:0] rsp_green,
   output logic [7:0] rsp_blue,
   output logic       rsp_frame_done,
   input  logic       csr_write,
   input  logic       csr_index,
   input  logic [9:0] csr_data
);

   localparam int LAW = yprgb_pkg::LUMA_AW;
   localparam int CAW = yprgb_pkg::CB_AW;

   function automatic logic [7:0] clamp_byte(logic [7:0] b, logic [7:0] lo,
                                             logic [7:0] hi);
      logic [7:0] res;
      if (b < lo) res = lo;
      else if (b > hi) res = hi;
      else res = b;
      return res;
   endfunction

   // floor(sum / 1024) clamped to 0..255
   function automatic logic [7:0] pix_clamp(logic signed [yprgb_pkg::SUM_W-1:0] s);
      logic [7:0] res;
      if (s[yprgb_pkg::SUM_W-1]) res = 8'd0;
      else if (|s[yprgb_pkg::SUM_W-2:yprgb_pkg::FRAC_W+8]) res = 8'hFF;
      else res = s[yprgb_pkg::FRAC_W+7:yprgb_pkg::FRAC_W];
      return res;
   endfunction

   // ---------------- configuration ----------------
   logic [9:0] frame_width_ff;
   logic [8:0] frame_height_ff;
   logic       csr_restart;

   assign csr_restart = csr_write;   // both indexes are real registers

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= yprgb_pkg::FRAME_WIDTH_RST;
         frame_height_ff <= yprgb_pkg::FRAME_HEIGHT_RST;
      end else if (csr_write) begin
         if (csr_index == yprgb_pkg::CSR_FRAME_WIDTH) begin
            frame_width_ff <= csr_data;
         end else begin
            frame_height_ff <= csr_data[8:0];
         end
      end
   end

   // saturate, then force even
   logic [9:0] w_sat, w_eff;
   logic [8:0] h_sat, h_eff;

   always_comb begin
      if (frame_width_ff < 10'd2) w_sat = 10'd2;
      else if (frame_width_ff > yprgb_pkg::W_CAP) w_sat = yprgb_pkg::W_CAP;
      else w_sat = frame_width_ff;
      if (frame_height_ff < 9'd2) h_sat = 9'd2;
      else if (frame_height_ff > yprgb_pkg::H_CAP) h_sat = yprgb_pkg::H_CAP;
      else h_sat = frame_height_ff;
      w_eff = {w_sat[9:1], 1'b0};
      h_eff = {h_sat[8:1], 1'b0};
   end

   // ---------------- plane sequencer ----------------
   yprgb_pkg::phase_type phase_ff, phase_in;
   logic [8:0] row_pos_ff, row_pos_in;
   logic [9:0] col_pos_ff, col_pos_in;
   logic       is_luma, is_blue, is_red;
   logic [9:0] lim_col;
   logic [8:0] lim_row;
   logic [10:0] col_next;
   logic [9:0]  row_next;
   logic        col_wrap, row_wrap;
   logic        in_fire;
   logic        s1_free;

   always_comb begin
      is_luma = 1'b0;
      is_blue = 1'b0;
      is_red  = 1'b0;
      unique case (phase_ff)
         yprgb_pkg::PHASE_BLUE: is_blue = 1'b1;
         yprgb_pkg::PHASE_RED:  is_red  = 1'b1;
         default:               is_luma = 1'b1;   // unused code acts as luma
      endcase

      lim_col  = is_luma ? w_eff : {1'b0, w_eff[9:1]};
      lim_row  = is_luma ? h_eff : {1'b0, h_eff[8:1]};
      col_next = {1'b0, col_pos_ff} + 11'd1;
      row_next = {1'b0, row_pos_ff} + 10'd1;
      col_wrap = col_next >= {1'b0, lim_col};
      row_wrap = row_next >= {1'b0, lim_row};

      phase_in   = phase_ff;
      row_pos_in = row_pos_ff;
      col_pos_in = col_pos_ff;
      if (csr_restart) begin
         phase_in   = yprgb_pkg::PHASE_LUMA;
         row_pos_in = '0;
         col_pos_in = '0;
      end else if (in_fire) begin
         col_pos_in = col_wrap ? 10'd0 : col_next[9:0];
         if (col_wrap) begin
            row_pos_in = row_wrap ? 9'd0 : row_next[8:0];
            if (row_wrap) begin
               unique case (phase_ff)
                  yprgb_pkg::PHASE_BLUE: phase_in = yprgb_pkg::PHASE_RED;
                  yprgb_pkg::PHASE_RED:  phase_in = yprgb_pkg::PHASE_LUMA;
                  default:               phase_in = yprgb_pkg::PHASE_BLUE;
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= yprgb_pkg::PHASE_LUMA;
         row_pos_ff <= '0;
         col_pos_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         row_pos_ff <= row_pos_in;
         col_pos_ff <= col_pos_in;
      end
   end

   // Only Cr bytes wait, and only for the read stage.
   assign req_stall = is_red && !s1_free;
   assign in_fire   = req_valid && !req_stall;

   // ---------------- addressing ----------------
   // base = row * HALF_W; luma rows in the luma plane, block rows otherwise
   logic [LAW:0]   row_base;
   logic [LAW:0]   col_ext;
   logic [LAW-1:0] luma_wr_addr, luma_top_addr, luma_bot_addr;
   logic [CAW-1:0] cb_addr;

   always_comb begin
      row_base      = (LAW+1)'(row_pos_ff) * (LAW+1)'(yprgb_pkg::HALF_W);
      col_ext       = (LAW+1)'(col_pos_ff);
      luma_wr_addr  = LAW'(row_base + (col_ext >> 1));
      cb_addr       = CAW'(row_base + col_ext);
      luma_top_addr = LAW'((row_base << 1) + col_ext);
      luma_bot_addr = LAW'((row_base << 1) + (LAW+1)'(yprgb_pkg::HALF_W) + col_ext);
   end

   // ---------------- stores ----------------
   logic [7:0]  luma_clamped, chroma_clamped;
   logic [7:0]  even_byte_ff;
   logic        luma_wr, cb_wr, rd_en;
   logic [15:0] luma_rd_top, luma_rd_bot;
   logic [7:0]  cb_rd;

   assign luma_clamped   = clamp_byte(req_plane_byte, yprgb_pkg::LUMA_LO,
                                      yprgb_pkg::LUMA_HI);
   assign chroma_clamped = clamp_byte(req_plane_byte, yprgb_pkg::CHROMA_LO,
                                      yprgb_pkg::CHROMA_HI);

   // luma is written as a pair on the odd column; the even byte waits here
   assign luma_wr = in_fire && is_luma && col_pos_ff[0];
   assign cb_wr   = in_fire && is_blue;
   assign rd_en   = in_fire && is_red;

   always_ff @(posedge clock) begin
      if (in_fire && is_luma && !col_pos_ff[0]) begin
         even_byte_ff <= luma_clamped;
      end
   end

   yprgb_ram #(
      .WIDTH (16),
      .DEPTH (yprgb_pkg::LUMA_DEPTH)
   ) u_luma_ram (
      .clock     (clock),
      .wr_en     (luma_wr),
      .wr_addr   (luma_wr_addr),
      .wr_data   ({luma_clamped, even_byte_ff}),
      .rd_en     (rd_en),
      .rd_addr_a (luma_top_addr),
      .rd_addr_b (luma_bot_addr),
      .rd_data_a (luma_rd_top),
      .rd_data_b (luma_rd_bot)
   );

   yprgb_ram #(
      .WIDTH (8),
      .DEPTH (yprgb_pkg::CB_DEPTH)
   ) u_cb_ram (
      .clock     (clock),
      .wr_en     (cb_wr),
      .wr_addr   (cb_addr),
      .wr_data   (chroma_clamped),
      .rd_en     (rd_en),
      .rd_addr_a (cb_addr),
      .rd_addr_b (cb_addr),
      .rd_data_a (cb_rd),
      .rd_data_b ()
   );

   // ---------------- read stage (s1) ----------------
   // RAM read data holds while s1 waits, so s1 needs no copy of it.
   logic       s1_valid_ff;
   logic [7:0] s1_cr_ff;
   logic [7:0] s1_row_ff;
   logic [8:0] s1_col_ff;
   logic       s1_last_ff;
   logic       s1_to_s2;

   logic       s2_valid_ff;
   logic [1:0] s2_k_ff;
   logic       s2_free, s2_adv, out_load;
   logic       rsp_valid_ff;

   assign out_load = !rsp_valid_ff || !rsp_stall;
   assign s2_adv   = s2_valid_ff && out_load;
   assign s2_free  = !s2_valid_ff || (s2_adv && (s2_k_ff == 2'd3));
   assign s1_to_s2 = s1_valid_ff && s2_free;
   assign s1_free  = !s1_valid_ff || s1_to_s2;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (rd_en) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_to_s2) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         s1_cr_ff   <= chroma_clamped;
         s1_row_ff  <= row_pos_ff[7:0];
         s1_col_ff  <= col_pos_ff[8:0];
         s1_last_ff <= row_wrap && col_wrap;
      end
   end

   // chroma terms, once per block
   logic signed [8:0]                   u_s, v_s;
   logic signed [yprgb_pkg::SUM_W-1:0]  r_term, g_term, b_term;

   always_comb begin
      u_s    = $signed({1'b0, cb_rd} - yprgb_pkg::CHROMA_OFS);
      v_s    = $signed({1'b0, s1_cr_ff} - yprgb_pkg::CHROMA_OFS);
      r_term = yprgb_pkg::SUM_W'(yprgb_pkg::COEF_RV) * yprgb_pkg::SUM_W'(v_s);
      g_term = -(yprgb_pkg::SUM_W'(yprgb_pkg::COEF_GU) * yprgb_pkg::SUM_W'(u_s)
                 + yprgb_pkg::SUM_W'(yprgb_pkg::COEF_GV) * yprgb_pkg::SUM_W'(v_s));
      b_term = yprgb_pkg::SUM_W'(yprgb_pkg::COEF_BU) * yprgb_pkg::SUM_W'(u_s);
   end

   // ---------------- block buffer (s2) ----------------
   logic [7:0]                         s2_luma_ff [4];
   logic signed [yprgb_pkg::SUM_W-1:0] s2_r_ff, s2_g_ff, s2_b_ff;
   logic [7:0]                         s2_row_ff;
   logic [8:0]                         s2_col_ff;
   logic                               s2_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s2_k_ff     <= '0;
      end else if (s1_to_s2) begin
         s2_valid_ff <= 1'b1;
         s2_k_ff     <= '0;
      end else if (s2_adv) begin
         s2_valid_ff <= (s2_k_ff != 2'd3);
         s2_k_ff     <= s2_k_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_to_s2) begin
         s2_luma_ff[0] <= luma_rd_top[7:0];
         s2_luma_ff[1] <= luma_rd_top[15:8];
         s2_luma_ff[2] <= luma_rd_bot[7:0];
         s2_luma_ff[3] <= luma_rd_bot[15:8];
         s2_r_ff       <= r_term;
         s2_g_ff       <= g_term;
         s2_b_ff       <= b_term;
         s2_row_ff     <= s1_row_ff;
         s2_col_ff     <= s1_col_ff;
         s2_last_ff    <= s1_last_ff;
      end
   end

   // ---------------- pixel math and output register ----------------
   logic [7:0]                         y_off;
   logic [yprgb_pkg::YSC_W-1:0]        y_scaled;
   logic signed [yprgb_pkg::SUM_W-1:0] y_term;
   logic [8:0]                         rsp_row_ff;
   logic [9:0]                         rsp_col_ff;
   logic [7:0]                         rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic                               rsp_done_ff;

   always_comb begin
      y_off    = s2_luma_ff[s2_k_ff] - yprgb_pkg::LUMA_OFS;
      y_scaled = yprgb_pkg::YSC_W'(yprgb_pkg::COEF_Y) * yprgb_pkg::YSC_W'(y_off);
      y_term   = $signed({{(yprgb_pkg::SUM_W-yprgb_pkg::YSC_W){1'b0}}, y_scaled});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         rsp_row_ff   <= {s2_row_ff, s2_k_ff[1]};
         rsp_col_ff   <= {s2_col_ff, s2_k_ff[0]};
         rsp_red_ff   <= pix_clamp(y_term + s2_r_ff);
         rsp_green_ff <= pix_clamp(y_term + s2_g_ff);
         rsp_blue_ff  <= pix_clamp(y_term + s2_b_ff);
         rsp_done_ff  <= s2_last_ff && (s2_k_ff == 2'd3);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_row  = rsp_row_ff;
   assign rsp_pixel_col  = rsp_col_ff;
   assign rsp_red        = rsp_red_ff;
   assign rsp_green      = rsp_green_ff;
   assign rsp_blue       = rsp_blue_ff;
   assign rsp_frame_done = rsp_done_ff;

endmodule

/* design/yprgb_checker.sv */
module yprgb_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_plane_byte,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [8:0] rsp_pixel_row,
   input logic [9:0] rsp_pixel_col,
   input logic [7:0] rsp_red,
   input logic [7:0] rsp_green,
   input logic [7:0] rsp_blue,
   input logic       rsp_frame_done,
   input logic       csr_write,
   input logic       csr_index,
   input logic [9:0] csr_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp transaction dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_pixel_row) && $stable(rsp_pixel_col)
         && $stable(rsp_red) && $stable(rsp_green) && $stable(rsp_blue)
         && $stable(rsp_frame_done))
      else $error("rsp payload changed while stalled");

   // frame end falls on a block's bottom-right pixel
   a_done_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_pixel_row[0] && rsp_pixel_col[0])
      else $error("frame_done away from bottom-right pixel");

   // top-left pixel taken: top-right of the same row follows at once
   a_block_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_pixel_row[0] && !rsp_pixel_col[0]
      |=> rsp_valid && rsp_pixel_col[0] && rsp_pixel_row == $past(rsp_pixel_row))
      else $error("2x2 block not emitted in order");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

endmodule

bind yuv420_planar_to_rgb yprgb_checker u_yprgb_checker (.*);

/* verif/rgb_pixel_checker.sv */
`timescale 1ns / 100ps

// Watches the plane-byte, pixel and size-register ports, keeps a shadow of the
// stored luma and Cb, and compares every pixel transaction with the next one due.
module rgb_pixel_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_plane_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [8:0] rsp_pixel_row,
   input  logic [9:0] rsp_pixel_col,
   input  logic [7:0] rsp_red,
   input  logic [7:0] rsp_green,
   input  logic [7:0] rsp_blue,
   input  logic       rsp_frame_done,
   input  logic       csr_write,
   input  logic       csr_index,
   input  logic [9:0] csr_data,
   output int         mismatch_total,
   output int         expected_left,
   output int         pixels_checked,
   output int         frames_closed
);

   // BT.601 gains, x1024
   localparam int Y_GAIN  = 1192;
   localparam int RV_GAIN = 1634;
   localparam int GU_GAIN = 401;
   localparam int GV_GAIN = 833;
   localparam int BU_GAIN = 2065;

   localparam int LUMA_FLOOR   = 16;
   localparam int LUMA_CEIL    = 235;
   localparam int CHROMA_FLOOR = 16;
   localparam int CHROMA_CEIL  = 240;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [8:0] row;
      logic [9:0] col;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       done;
   } rgb_pixel_type;

   bit [7:0]      luma_seen [yprgb_pkg::MAX_HEIGHT][yprgb_pkg::MAX_WIDTH];
   bit [7:0]      cb_seen [yprgb_pkg::HALF_H][yprgb_pkg::HALF_W];
   rgb_pixel_type pixels_due [$];

   int                   width_reg;
   int                   height_reg;
   yprgb_pkg::phase_type plane;
   int                   pos_row;
   int                   pos_col;
   int                   mismatches;
   int                   pixels;
   int                   frames;

   function automatic int usable_size(input int raw, input int cap);
      int v;
      v = (raw < 2) ? 2 : raw;
      if (v > cap) v = cap;
      return v & ~1;
   endfunction

   function automatic bit [7:0] clip(input bit [7:0] b, input int lo, input int hi);
      if (int'(b) < lo) return 8'(lo);
      if (int'(b) > hi) return 8'(hi);
      return b;
   endfunction

   function automatic bit [7:0] to_channel(input int acc);
      int scaled;
      if (acc < 0) return 8'd0;
      scaled = acc / 1024;
      return (scaled > 255) ? 8'd255 : 8'(scaled);
   endfunction

   // raster walk within the current plane; wraps into the next plane
   function automatic void step_position(input int cols, input int rows,
                                         input yprgb_pkg::phase_type after);
      pos_col++;
      if (pos_col >= cols) begin
         pos_col = 0;
         pos_row++;
         if (pos_row >= rows) begin
            pos_row = 0;
            plane   = after;
         end
      end
   endfunction

   always @(posedge clock) begin : watch
      int            w;
      int            h;
      int            k;
      int            r;
      int            c;
      int            y_v;
      int            cb_u;
      int            cr_v;
      bit            last;
      rgb_pixel_type px;
      rgb_pixel_type got;

      if (reset) begin
         width_reg  = int'(yprgb_pkg::FRAME_WIDTH_RST);
         height_reg = int'(yprgb_pkg::FRAME_HEIGHT_RST);
         plane      = yprgb_pkg::PHASE_LUMA;
         pos_row    = 0;
         pos_col    = 0;
         pixels_due.delete();
      end else begin
         // size write: frame restarts, stores keep their contents
         if (csr_write) begin
            if (csr_index == yprgb_pkg::CSR_FRAME_WIDTH) width_reg = int'(csr_data);
            else height_reg = int'(csr_data[8:0]);
            plane   = yprgb_pkg::PHASE_LUMA;
            pos_row = 0;
            pos_col = 0;
         end

         if (req_valid && !req_stall) begin
            w = usable_size(width_reg, yprgb_pkg::MAX_WIDTH);
            h = usable_size(height_reg, yprgb_pkg::MAX_HEIGHT);
            case (plane)
               yprgb_pkg::PHASE_BLUE: begin
                  cb_seen[pos_row][pos_col] = clip(req_plane_byte, CHROMA_FLOOR, CHROMA_CEIL);
                  step_position(w / 2, h / 2, yprgb_pkg::PHASE_RED);
               end
               yprgb_pkg::PHASE_RED: begin
                  cr_v = int'(clip(req_plane_byte, CHROMA_FLOOR, CHROMA_CEIL)) - 128;
                  cb_u = int'(cb_seen[pos_row][pos_col]) - 128;
                  last = (pos_row + 1 >= h / 2) && (pos_col + 1 >= w / 2);
                  for (k = 0; k < 4; k++) begin
                     r         = 2 * pos_row + k / 2;
                     c         = 2 * pos_col + k % 2;
                     y_v       = int'(luma_seen[r][c]) - 16;
                     px.row    = 9'(r);
                     px.col    = 10'(c);
                     px.red    = to_channel(Y_GAIN * y_v + RV_GAIN * cr_v);
                     px.green  = to_channel(Y_GAIN * y_v - GU_GAIN * cb_u - GV_GAIN * cr_v);
                     px.blue   = to_channel(Y_GAIN * y_v + BU_GAIN * cb_u);
                     px.done   = last && (k == 3);
                     pixels_due = {pixels_due, px};
                  end
                  step_position(w / 2, h / 2, yprgb_pkg::PHASE_LUMA);
               end
               default: begin
                  plane = yprgb_pkg::PHASE_LUMA;
                  luma_seen[pos_row][pos_col] = clip(req_plane_byte, LUMA_FLOOR, LUMA_CEIL);
                  step_position(w, h, yprgb_pkg::PHASE_BLUE);
               end
            endcase
         end

         if (rsp_valid && !rsp_stall) begin
            got.row   = rsp_pixel_row;
            got.col   = rsp_pixel_col;
            got.red   = rsp_red;
            got.green = rsp_green;
            got.blue  = rsp_blue;
            got.done  = rsp_frame_done;
            pixels++;
            if (got.done === 1'b1) frames++;
            if (pixels_due.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("unexpected pixel: row %0d col %0d rgb %0d,%0d,%0d last %0d",
                           got.row, got.col, got.red, got.green, got.blue, got.done);
            end else begin
               px = pixels_due.pop_front();
               if (px !== got) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display({"pixel mismatch: want r%0d c%0d rgb %0d,%0d,%0d last %0d,",
                               " got r%0d c%0d rgb %0d,%0d,%0d last %0d"},
                              px.row, px.col, px.red, px.green, px.blue, px.done,
                              got.row, got.col, got.red, got.green, got.blue, got.done);
               end
            end
         end
      end

      mismatch_total <= mismatches;
      expected_left  <= pixels_due.size();
      pixels_checked <= pixels;
      frames_closed  <= frames;
   end

endmodule

/* verif/yuv420_planar_to_rgb_tb.sv */
`timescale 1ns / 100ps

// Top of the converter testbench: clock, reset, plane-byte stimulus, output
// stall pattern, watchdog and verdict. Prediction and compare live in the
// checker beside the block.
module yuv420_planar_to_rgb_tb;

   localparam int SETTLE_CYCLES  = 12;     // covers a Cr byte's pass through to its four pixels, with slack
   localparam int HOLD_CYCLES    = 400;    // long output hold, fills the block
   localparam int WATCHDOG_LIMIT = 20000;  // cycles with no transaction at all
   localparam int RANDOM_BYTES   = 80;

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_stall;
   logic [7:0] req_plane_byte = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall      = 1'b0;
   logic [8:0] rsp_pixel_row;
   logic [9:0] rsp_pixel_col;
   logic [7:0] rsp_red;
   logic [7:0] rsp_green;
   logic [7:0] rsp_blue;
   logic       rsp_frame_done;
   logic       csr_write      = 1'b0;
   logic       csr_index      = 1'b0;
   logic [9:0] csr_data       = 10'd0;

   int mismatch_total;
   int expected_left;
   int pixels_checked;
   int frames_closed;

   // Pacing knobs. stall_pct is read by the stall process at the clock edge,
   // so it is only ever updated with nonblocking assignments.
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;

   // Long-hold handshake between stimulus and the stall process: stimulus
   // bumps hold_requests, the stall process serves each request once.
   int hold_requests = 0;
   int holds_served  = 0;
   int hold_left     = 0;
   bit squeeze_next  = 1'b0;   // start a long hold when the Cr plane begins
   bit breather_next = 1'b0;   // pause mid Cr plane until all pixels are back

   int bytes_sent   = 0;
   int random_bytes = 0;
   int size_writes  = 0;
   int quiet_cycles = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   yuv420_planar_to_rgb u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_plane_byte (req_plane_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_row  (rsp_pixel_row),
      .rsp_pixel_col  (rsp_pixel_col),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_frame_done (rsp_frame_done),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   rgb_pixel_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_plane_byte (req_plane_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_row  (rsp_pixel_row),
      .rsp_pixel_col  (rsp_pixel_col),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_frame_done (rsp_frame_done),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_total (mismatch_total),
      .expected_left  (expected_left),
      .pixels_checked (pixels_checked),
      .frames_closed  (frames_closed)
   );

   // Output side: random stalls at stall_pct, or a long unbroken hold when
   // stimulus asks for one. The hold is counted here, not in stimulus, so the
   // sender keeps offering Cr bytes and the block has to push back on req.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall    <= 1'b0;
         hold_left    <= 0;
         holds_served <= 0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
         rsp_stall    <= 1'b1;
         hold_left    <= HOLD_CYCLES;
         holds_served <= holds_served + 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // Watchdog: any transaction on any port resets the count.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles, %0d pixels still due",
                  quiet_cycles, expected_left);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Size in use for a register value: saturate to 2..cap, round down to even.
   function automatic int active_dim(input int raw, input int cap);
      int v;
      v = (raw < 2) ? 2 : raw;
      if (v > cap) v = cap;
      return v & ~1;
   endfunction

   // Mode 0: no idling. 1: sender idle 80%. 2: receiver stalls 80%. 3: both 19%.
   task automatic set_pace(input int mode);
      case (mode)
         1: begin send_idle_pct = 80; stall_pct <= 0;  end
         2: begin send_idle_pct = 0;  stall_pct <= 80; end
         3: begin send_idle_pct = 19; stall_pct <= 19; end
         default: begin send_idle_pct = 0; stall_pct <= 0; end
      endcase
   endtask

   // One plane-byte transaction. Valid is decided before it goes up and then
   // held with a stable byte until the block takes it.
   task automatic send_byte(input logic [7:0] value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_plane_byte <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   // Drop valid and wait until every predicted pixel has come back, then give
   // the block time to finish luma/Cb bytes that return nothing.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Width and height written on back-to-back cycles while idle.
   task automatic program_size(input int w_reg, input int h_reg);
      drain_results();
      csr_write <= 1'b1;
      csr_index <= yprgb_pkg::CSR_FRAME_WIDTH;
      csr_data  <= 10'(w_reg);
      @(posedge clock);
      csr_index <= yprgb_pkg::CSR_FRAME_HEIGHT;
      csr_data  <= 10'(h_reg);
      @(posedge clock);
      csr_write <= 1'b0;
      size_writes++;
   endtask

   // Random-content frame: luma, then Cb, then Cr bytes; stops after `cut`
   // bytes to leave a broken frame behind. Byte values lean toward the clamp
   // edges now and then.
   task automatic send_frame(input int w_eff, input int h_eff, input int cut,
                             output int sent);
      int total;
      int cr_first;
      int n;
      logic [7:0] b;
      total    = w_eff * h_eff * 3 / 2;
      cr_first = w_eff * h_eff * 5 / 4;
      sent     = 0;
      for (n = 0; n < total && n < cut; n++) begin
         if (n == cr_first && squeeze_next) begin
            hold_requests <= hold_requests + 1;
            squeeze_next = 1'b0;
         end
         if (n == cr_first + (total - cr_first) / 2 && breather_next) begin
            drain_results();
            breather_next = 1'b0;
         end
         case ($urandom_range(0, 7))
            0:       b = 8'($urandom_range(0, 20));
            1:       b = 8'($urandom_range(230, 255));
            default: b = 8'($urandom_range(0, 255));
         endcase
         send_byte(b);
         sent++;
      end
   endtask

   initial begin : stimulus
      logic [7:0] series [$];
      int         w_reg;
      int         h_reg;
      int         w_eff;
      int         h_eff;
      int         frame_bytes;
      int         cut;
      int         sent;
      int         frame_no;
      bit         restart_due;

      while (reset) @(posedge clock);

      // --- directed ---------------------------------------------------------
      // Width 0 and height 1 both saturate up to a 2x2 frame.
      program_size(0, 1);
      set_pace(0);
      // Two 2x2 frames back to back (frame end wraps to luma). Luma at and
      // beyond both clamp edges; Cb/Cr at the opposite extremes so the RGB
      // sums run past 255 and below 0.
      series = '{8'd0,  8'd255, 8'd16,  8'd235, 8'd0,   8'd255,
                 8'd15, 8'd236, 8'd128, 8'd200, 8'd255, 8'd0};
      foreach (series[i]) send_byte(series[i]);

      // Broken frame: a few luma bytes, then a size write restarts at luma.
      set_pace(3);
      series = '{8'd90, 8'd91, 8'd92};
      foreach (series[i]) send_byte(series[i]);
      // Odd sizes round down: 3x3 runs as 2x2.
      program_size(3, 3);
      series = '{8'd235, 8'd235, 8'd16, 8'd16, 8'd240, 8'd240};
      foreach (series[i]) send_byte(series[i]);

      // --- random frames ----------------------------------------------------
      // Mostly small, well-formed frames with random content; sizes include
      // 0, 1 and odd values. Some frames follow without a size write, and
      // about one in eight is cut short and restarted by the next write.
      frame_no    = 0;
      restart_due = 1'b1;
      while (random_bytes < RANDOM_BYTES) begin
         if (restart_due || $urandom_range(0, 2) != 0) begin
            w_reg = $urandom_range(0, 11);
            h_reg = $urandom_range(0, 7);
            program_size(w_reg, h_reg);
            w_eff = active_dim(w_reg, yprgb_pkg::MAX_WIDTH);
            h_eff = active_dim(h_reg, yprgb_pkg::MAX_HEIGHT);
         end
         set_pace(frame_no % 4);
         frame_bytes = w_eff * h_eff * 3 / 2;
         cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, frame_bytes - 1) : frame_bytes;
         restart_due = (cut < frame_bytes);
         send_frame(w_eff, h_eff, cut, sent);
         random_bytes += sent;
         frame_no++;
      end

      // --- back pressure ----------------------------------------------------
      // 8x6 frame with a long output hold from the first Cr byte on, so the
      // block backs up and stalls req while Cr bytes keep coming.
      program_size(8, 6);
      set_pace(0);
      squeeze_next = 1'b1;
      send_frame(8, 6, 8 * 6 * 3 / 2, sent);

      // 4x4 frame with a busy receiver; the sender stops halfway through Cr
      // until every pixel is back.
      program_size(4, 4);
      set_pace(2);
      breather_next = 1'b1;
      send_frame(4, 4, 4 * 4 * 3 / 2, sent);

      drain_results();

      $display("run: %0d size settings, %0d plane bytes sent (%0d in random frames)",
               size_writes, bytes_sent, random_bytes);
      $display("run: %0d pixels compared, %0d frames closed, sizes 2x2 to 10x6, long hold",
               pixels_checked, frames_closed);
      if (mismatch_total == 0 && expected_left == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatching pixels, %0d still due", mismatch_total, expected_left);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
